// ===== design/tile_pkg.sv =====
`timescale 1ns / 1ps
// Package for the letter trie engine: request, result and queue entry types
// and the fixed constants. No dependencies.
package tile_pkg;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_TRANS  = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [7:0] LETTER_FIRST = 8'd65;
    localparam logic [7:0] LETTER_LAST  = 8'd90;
    localparam int FANOUT = 26;
    localparam int LIDX_W = 5;
    localparam int NODE_OUT_W = 12;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    typedef struct packed {
        logic [1:0]            cmd;
        logic [7:0]            letter;
        logic                  word_last;
        logic [NODE_OUT_W-1:0] node_in;
        logic                  node_in_valid;
    } tile_req_t;

    typedef struct packed {
        logic                  word_found;
        logic                  prefix_found;
        logic [NODE_OUT_W-1:0] node_out;
        logic                  node_out_valid;
        logic                  is_terminal;
        logic                  overflow;
    } tile_res_t;

    typedef struct packed {
        logic [1:0]            kind;
        logic                  letter_ok;
        logic [LIDX_W-1:0]     lidx;
        logic                  last;
        logic [NODE_OUT_W-1:0] node;
        logic                  node_ok;
    } tile_op_t;

endpackage

// ===== design/tile_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts requests and classifies them into queue entries.
// Depends on tile_pkg.
module tile_front (
    input  logic               req_valid,
    output logic               req_stall,
    input  tile_pkg::tile_req_t req_data,
    input  logic               busy,
    input  logic               q_full,
    output logic               push,
    output tile_pkg::tile_op_t push_op
);
    import tile_pkg::*;

    logic letter_ok;
    logic [7:0] letter_off;

    always_comb
    begin
        req_stall = busy | q_full;
        letter_ok = (req_data.letter >= LETTER_FIRST) && (req_data.letter <= LETTER_LAST);
        letter_off = req_data.letter - LETTER_FIRST;
        push = req_valid && !req_stall && (req_data.cmd != CMD_UNUSED);
        push_op.kind = req_data.cmd;
        push_op.letter_ok = letter_ok;
        push_op.lidx = letter_ok ? letter_off[LIDX_W-1:0] : '0;
        push_op.last = req_data.word_last;
        push_op.node = req_data.node_in;
        push_op.node_ok = req_data.node_in_valid;
    end

endmodule

// ===== design/tile_queue.sv =====
`timescale 1ns / 1ps
// Short queue of classified requests between the front and the back end.
// Depends on tile_pkg.
module tile_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  tile_pkg::tile_op_t push_op,
    input  logic               pop,
    output logic               valid,
    output tile_pkg::tile_op_t head,
    output logic               full
);
    import tile_pkg::*;

    tile_op_t entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic [Q_CNT_W-1:0] count_next;

    always_comb
    begin
        valid = count_reg != '0;
        full = count_reg == Q_CNT_W'(Q_DEPTH);
        head = entry_reg[rd_ptr_reg];
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + Q_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

// ===== design/tile_back.sv =====
`timescale 1ns / 1ps
// Back end: node store, end marks, walk state and the result register.
// Depends on tile_pkg; fed by tile_queue.
module tile_back #(
    parameter int NODE_COUNT = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  tile_pkg::tile_op_t  q_op,
    output logic                q_pop,
    output logic                busy,
    output logic                res_valid,
    input  logic                res_stall,
    output tile_pkg::tile_res_t res_data
);
    import tile_pkg::*;

    localparam int NODE_W = $clog2(NODE_COUNT);
    localparam int CNT_W = NODE_W + 1;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_ROW   = 3'd2;
    localparam logic [2:0] ST_END   = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    typedef logic [FANOUT-1:0][NODE_W-1:0] row_t;

    row_t row_mem [NODE_COUNT];
    logic end_mem [NODE_COUNT];

    logic [2:0] state_reg, state_next;
    logic [NODE_W-1:0] clr_reg, clr_next;
    tile_op_t op_reg, op_next;
    logic [NODE_W-1:0] walk_reg, walk_next;
    logic failed_reg, failed_next;
    logic ovf_reg, ovf_next;
    logic [CNT_W-1:0] used_reg, used_next;
    tile_res_t res_reg, res_next;
    logic out_valid_reg, out_valid_next;
    tile_res_t out_reg, out_next;

    logic row_we;
    logic [NODE_W-1:0] row_waddr, row_raddr;
    row_t row_wdata, row_rdata_reg;
    logic end_we, end_wdata, end_rdata_reg;
    logic [NODE_W-1:0] end_waddr, end_raddr;

    logic [NODE_W-1:0] child, w;
    logic o, f;
    logic [NODE_W+NODE_OUT_W-1:0] q_src_wide, op_src_wide;
    logic op_in_range;

    function automatic logic [NODE_OUT_W-1:0] node12(input logic [NODE_W-1:0] n);
        logic [NODE_W+NODE_OUT_W-1:0] wide;
        wide = {{NODE_OUT_W{1'b0}}, n};
        return wide[NODE_OUT_W-1:0];
    endfunction

    always_comb
    begin
        state_next = state_reg;
        clr_next = clr_reg;
        op_next = op_reg;
        walk_next = walk_reg;
        failed_next = failed_reg;
        ovf_next = ovf_reg;
        used_next = used_reg;
        res_next = res_reg;
        out_valid_next = out_valid_reg && res_stall;
        out_next = out_reg;
        q_pop = 1'b0;
        row_we = 1'b0;
        row_waddr = walk_reg;
        row_wdata = row_rdata_reg;
        row_raddr = walk_reg;
        end_we = 1'b0;
        end_waddr = walk_reg;
        end_wdata = 1'b1;
        end_raddr = walk_reg;
        child = row_rdata_reg[op_reg.lidx];
        w = walk_reg;
        o = ovf_reg;
        f = failed_reg;
        q_src_wide = {{NODE_W{1'b0}}, q_op.node};
        op_src_wide = {{NODE_W{1'b0}}, op_reg.node};
        op_in_range = op_src_wide < (NODE_W + NODE_OUT_W)'(NODE_COUNT);

        case (state_reg)
            ST_CLEAR:
            begin
                row_we = 1'b1;
                row_waddr = clr_reg;
                row_wdata = '0;
                end_we = 1'b1;
                end_waddr = clr_reg;
                end_wdata = 1'b0;
                clr_next = clr_reg + NODE_W'(1);
                if (clr_reg == NODE_W'(NODE_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    op_next = q_op;
                    if (q_op.kind == CMD_TRANS)
                    begin
                        row_raddr = q_src_wide[NODE_W-1:0];
                    end
                    state_next = ST_ROW;
                end
            end
            ST_ROW:
            begin
                res_next = '0;
                state_next = ST_IDLE;
                case (op_reg.kind)
                    CMD_INSERT:
                    begin
                        if (!o && op_reg.letter_ok)
                        begin
                            if (child == '0)
                            begin
                                if (used_reg < CNT_W'(NODE_COUNT))
                                begin
                                    row_we = 1'b1;
                                    row_wdata[op_reg.lidx] = used_reg[NODE_W-1:0];
                                    w = used_reg[NODE_W-1:0];
                                    used_next = used_reg + CNT_W'(1);
                                end
                                else
                                begin
                                    o = 1'b1;
                                end
                            end
                            else
                            begin
                                w = child;
                            end
                        end
                        walk_next = w;
                        ovf_next = o;
                        if (op_reg.last)
                        begin
                            if (o)
                            begin
                                res_next.overflow = 1'b1;
                            end
                            else
                            begin
                                end_we = 1'b1;
                                end_waddr = w;
                                res_next.node_out = node12(w);
                                res_next.node_out_valid = 1'b1;
                            end
                            walk_next = '0;
                            ovf_next = 1'b0;
                            failed_next = 1'b0;
                            state_next = ST_EMIT;
                        end
                    end
                    CMD_LOOKUP:
                    begin
                        if (!f)
                        begin
                            if (!op_reg.letter_ok || child == '0)
                            begin
                                f = 1'b1;
                            end
                            else
                            begin
                                w = child;
                            end
                        end
                        walk_next = w;
                        failed_next = f;
                        if (op_reg.last)
                        begin
                            res_next.prefix_found = !f;
                            end_raddr = w;
                            walk_next = '0;
                            ovf_next = 1'b0;
                            failed_next = 1'b0;
                            state_next = ST_END;
                        end
                    end
                    CMD_TRANS:
                    begin
                        if (op_reg.node_ok && op_reg.letter_ok && op_in_range && child != '0)
                        begin
                            res_next.node_out = node12(child);
                            res_next.node_out_valid = 1'b1;
                        end
                        end_raddr = child;
                        state_next = ST_END;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_END:
            begin
                res_next.word_found = res_reg.prefix_found & end_rdata_reg;
                res_next.is_terminal = res_reg.node_out_valid & end_rdata_reg;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || !res_stall)
                begin
                    out_valid_next = 1'b1;
                    out_next = res_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg <= '0;
            walk_reg <= '0;
            failed_reg <= 1'b0;
            ovf_reg <= 1'b0;
            used_reg <= CNT_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            walk_reg <= walk_next;
            failed_reg <= failed_next;
            ovf_reg <= ovf_next;
            used_reg <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            row_mem[row_waddr] <= row_wdata;
        end
        row_rdata_reg <= row_mem[row_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (end_we)
        begin
            end_mem[end_waddr] <= end_wdata;
        end
        end_rdata_reg <= end_mem[end_raddr];
    end

    assign busy = state_reg == ST_CLEAR;
    assign res_valid = out_valid_reg;
    assign res_data = out_reg;

endmodule

// ===== design/trie_insert_lookup_engine_top.sv =====
`timescale 1ns / 1ps
// Top level of the letter trie engine: front end, queue and back end.
// Depends on tile_pkg, tile_front, tile_queue and tile_back.
//
//   channel   valid      stall      payload
//   request   req_valid  req_stall  req_data (tile_req_t)
//   result    res_valid  res_stall  res_data (tile_res_t)
//
// A character that causes no result goes through the back end as a node row
// read, then the child select and any allocation write.
// A final insert character then goes on to the emit step; a final lookup
// character or a transition goes through the end-mark memory read before it.
// After reset a clearing pass writes zero into every entry of both memories.
// Requests are held off during that pass, and the queue keeps taking
// requests until full while a result waits on a stalled result channel.
module trie_insert_lookup_engine_top #(
    parameter int NODE_COUNT = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  tile_pkg::tile_req_t req_data,
    output logic                res_valid,
    input  logic                res_stall,
    output tile_pkg::tile_res_t res_data
);
    import tile_pkg::*;

    logic busy;
    logic q_full;
    logic push;
    tile_op_t push_op;
    logic pop;
    logic q_valid;
    tile_op_t q_head;

    tile_front u_front (
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .busy      (busy),
        .q_full    (q_full),
        .push      (push),
        .push_op   (push_op)
    );

    tile_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .valid   (q_valid),
        .head    (q_head),
        .full    (q_full)
    );

    tile_back #(
        .NODE_COUNT (NODE_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_op      (q_head),
        .q_pop     (pop),
        .busy      (busy),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (!res_valid && req_stall))
        else $error("activity during the clearing pass");

    a_null_target: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_data.node_out_valid) |->
        (res_data.node_out == '0 && !res_data.is_terminal))
        else $error("null target carries a node or terminal flag");

    a_overflow_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_data.overflow) |->
        (!res_data.node_out_valid && !res_data.word_found && !res_data.prefix_found))
        else $error("overflow result carries other flags");

    a_word_has_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_data.word_found) |-> res_data.prefix_found)
        else $error("word found without its prefix");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for trie_insert_lookup_engine_top: a directed request table, then
// random request traffic under varied stalls, checked against a trie model kept in the bench.
// Depends on tile_pkg and the engine RTL.
module testbench;
    import tile_pkg::*;

    localparam int NODES = 4096;
    localparam int QUIET_LIMIT = 30000;
    localparam tile_res_t NO_RES = '0;

    typedef struct packed {
        logic [1:0]            cmd;
        logic [7:0]            letter;
        logic                  last;
        logic [NODE_OUT_W-1:0] node;
        logic                  node_ok;
        logic                  typed;
        tile_res_t             ans;
    } script_row_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    tile_req_t req_data = '0;
    logic      res_valid;
    logic      res_stall = 1'b0;
    tile_res_t res_data;

    int unsigned kids [NODES*FANOUT];
    bit          marks [NODES];
    int unsigned nodes_taken = 1;
    int unsigned walk_at = 0;
    bit          walk_lost = 1'b0;
    bit          walk_overflowed = 1'b0;

    tile_res_t answers_due [$];
    string     words_seen [$];
    int        fault_count = 0;
    int        request_count = 0;
    int        send_gap_pct = 0;
    int        recv_gap_pct = 0;
    int        hold_left = 0;
    int        quiet_cycles = 0;

    script_row_t script [0:22] = '{
        '{CMD_LOOKUP, "A", 1'b1, 12'd0, 1'b0, 1'b1, NO_RES},
        '{CMD_TRANS, "A", 1'b0, 12'd0, 1'b1, 1'b1, NO_RES},
        '{CMD_INSERT, "A", 1'b0, 12'd0, 1'b0, 1'b0, NO_RES},
        '{CMD_INSERT, "@", 1'b0, 12'd0, 1'b0, 1'b0, NO_RES},
        '{CMD_INSERT, "Z", 1'b1, 12'd0, 1'b0, 1'b1, '{1'b0, 1'b0, 12'd2, 1'b1, 1'b0, 1'b0}},
        '{CMD_LOOKUP, "A", 1'b0, 12'd0, 1'b0, 1'b0, NO_RES},
        '{CMD_LOOKUP, "Z", 1'b1, 12'd0, 1'b0, 1'b1, '{1'b1, 1'b1, 12'd0, 1'b0, 1'b0, 1'b0}},
        '{CMD_LOOKUP, "A", 1'b1, 12'd0, 1'b0, 1'b1, '{1'b0, 1'b1, 12'd0, 1'b0, 1'b0, 1'b0}},
        '{CMD_LOOKUP, "[", 1'b0, 12'd0, 1'b0, 1'b0, NO_RES},
        '{CMD_LOOKUP, "A", 1'b1, 12'd0, 1'b0, 1'b1, NO_RES},
        '{CMD_TRANS, "Z", 1'b0, 12'd1, 1'b1, 1'b1, '{1'b0, 1'b0, 12'd2, 1'b1, 1'b1, 1'b0}},
        '{CMD_TRANS, "Z", 1'b0, 12'd1, 1'b0, 1'b1, NO_RES},
        '{CMD_TRANS, 8'hFF, 1'b1, 12'd0, 1'b1, 1'b1, NO_RES},
        '{CMD_TRANS, "A", 1'b0, 12'd4095, 1'b1, 1'b1, NO_RES},
        '{CMD_UNUSED, "A", 1'b1, 12'd4095, 1'b1, 1'b0, NO_RES},
        '{CMD_INSERT, 8'h00, 1'b1, 12'd0, 1'b0, 1'b1, '{1'b0, 1'b0, 12'd0, 1'b1, 1'b0, 1'b0}},
        '{CMD_LOOKUP, "Q", 1'b1, 12'd0, 1'b0, 1'b1, NO_RES},
        '{CMD_INSERT, "A", 1'b0, 12'd0, 1'b0, 1'b0, NO_RES},
        '{CMD_LOOKUP, "Z", 1'b1, 12'd0, 1'b0, 1'b0, NO_RES},
        '{CMD_INSERT, "M", 1'b1, 12'd4095, 1'b1, 1'b0, NO_RES},
        '{CMD_TRANS, "A", 1'b0, 12'd0, 1'b1, 1'b1, '{1'b0, 1'b0, 12'd1, 1'b1, 1'b0, 1'b0}},
        '{CMD_TRANS, "M", 1'b1, 12'd0, 1'b1, 1'b0, NO_RES},
        '{CMD_LOOKUP, 8'h80, 1'b1, 12'd0, 1'b0, 1'b0, NO_RES}
    };

    trie_insert_lookup_engine_top #(.NODE_COUNT(NODES)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    always #2 clk = ~clk;

    function automatic bit is_letter(logic [7:0] c);
        return c >= LETTER_FIRST && c <= LETTER_LAST;
    endfunction

    task automatic step_trie(input tile_req_t r, output bit got, output tile_res_t ans);
        int unsigned slot;
        int unsigned nxt;
        got = 1'b0;
        ans = '0;
        case (r.cmd)
            CMD_INSERT:
            begin
                if (!walk_overflowed && is_letter(r.letter))
                begin
                    slot = walk_at * FANOUT + (r.letter - LETTER_FIRST);
                    nxt = kids[slot];
                    if (nxt == 0)
                    begin
                        if (nodes_taken < NODES)
                        begin
                            nxt = nodes_taken;
                            kids[slot] = nxt;
                            nodes_taken++;
                        end
                        else
                            walk_overflowed = 1'b1;
                    end
                    if (!walk_overflowed)
                        walk_at = nxt;
                end
                if (r.word_last)
                begin
                    got = 1'b1;
                    if (walk_overflowed)
                        ans.overflow = 1'b1;
                    else
                    begin
                        marks[walk_at] = 1'b1;
                        ans.node_out = walk_at[NODE_OUT_W-1:0];
                        ans.node_out_valid = 1'b1;
                    end
                end
            end
            CMD_LOOKUP:
            begin
                if (!walk_lost)
                begin
                    if (!is_letter(r.letter))
                        walk_lost = 1'b1;
                    else
                    begin
                        nxt = kids[walk_at * FANOUT + (r.letter - LETTER_FIRST)];
                        if (nxt == 0)
                            walk_lost = 1'b1;
                        else
                            walk_at = nxt;
                    end
                end
                if (r.word_last)
                begin
                    got = 1'b1;
                    if (!walk_lost)
                    begin
                        ans.prefix_found = 1'b1;
                        ans.word_found = marks[walk_at];
                    end
                end
            end
            CMD_TRANS:
            begin
                got = 1'b1;
                if (r.node_in_valid && is_letter(r.letter) && r.node_in < NODES)
                begin
                    nxt = kids[r.node_in * FANOUT + (r.letter - LETTER_FIRST)];
                    if (nxt != 0 && nxt < NODES)
                    begin
                        ans.node_out = nxt[NODE_OUT_W-1:0];
                        ans.node_out_valid = 1'b1;
                        ans.is_terminal = marks[nxt];
                    end
                end
            end
            default:
            begin
            end
        endcase
        if ((r.cmd == CMD_INSERT || r.cmd == CMD_LOOKUP) && r.word_last)
        begin
            walk_at = 0;
            walk_lost = 1'b0;
            walk_overflowed = 1'b0;
        end
    endtask

    task automatic offer(input tile_req_t r, input bit typed, input tile_res_t typed_ans);
        bit        got;
        tile_res_t ans;
        if (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data <= r;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        step_trie(r, got, ans);
        if (got)
            answers_due = {answers_due, (typed ? typed_ans : ans)};
        if (r.cmd != CMD_UNUSED)
            request_count++;
    endtask

    function automatic string make_word(int len, int span, int junk_pct);
        string      s = "";
        logic [7:0] ch;
        for (int i = 0; i < len; i++)
        begin
            ch = 8'(LETTER_FIRST + $urandom_range(span - 1));
            if ($urandom_range(99) < junk_pct)
                ch = 8'($urandom_range(255, 1));
            s = $sformatf("%s%c", s, ch);
        end
        return s;
    endfunction

    task automatic send_word(string w, logic [1:0] cmd, bit mixed);
        tile_req_t r;
        for (int i = 0; i < w.len(); i++)
        begin
            r.cmd = mixed ? ($urandom_range(1) ? CMD_INSERT : CMD_LOOKUP) : cmd;
            r.letter = w[i];
            r.word_last = (i == w.len() - 1);
            r.node_in = 12'($urandom_range(4095));
            r.node_in_valid = 1'($urandom_range(1));
            offer(r, 1'b0, NO_RES);
        end
    endtask

    task automatic remember_word(string w);
        if (words_seen.size() < 200)
            words_seen = {words_seen, w};
        else
            words_seen[$urandom_range(199)] = w;
    endtask

    task automatic random_request();
        int        pick;
        int        span;
        string     w;
        tile_req_t r;
        pick = $urandom_range(99);
        span = $urandom_range(1) ? 4 : 26;
        if (pick < 35)
        begin
            w = make_word($urandom_range(5, 1), span, 3);
            send_word(w, CMD_INSERT, 1'b0);
            remember_word(w);
        end
        else if (pick < 62)
        begin
            if (words_seen.size() > 0 && $urandom_range(99) < 75)
            begin
                w = words_seen[$urandom_range(words_seen.size() - 1)];
                case ($urandom_range(2))
                    0: w = w.substr(0, $urandom_range(w.len() - 1));
                    1: w = $sformatf("%s%c", w, LETTER_FIRST + $urandom_range(3));
                    default:
                    begin
                    end
                endcase
            end
            else
                w = make_word($urandom_range(5, 1), span, 5);
            send_word(w, CMD_LOOKUP, 1'b0);
        end
        else if (pick < 84)
        begin
            r.cmd = CMD_TRANS;
            case ($urandom_range(3))
                0, 1: r.letter = 8'(LETTER_FIRST + $urandom_range(3));
                2: r.letter = 8'(LETTER_FIRST + $urandom_range(25));
                default: r.letter = 8'($urandom_range(255));
            endcase
            r.word_last = 1'($urandom_range(1));
            r.node_in = ($urandom_range(99) < 75) ? 12'($urandom_range(nodes_taken - 1))
                                                  : 12'($urandom_range(4095));
            r.node_in_valid = ($urandom_range(9) != 0);
            offer(r, 1'b0, NO_RES);
        end
        else if (pick < 92)
            send_word(make_word($urandom_range(5, 1), 4, 3), CMD_INSERT, 1'b1);
        else
        begin
            r.cmd = 2'($urandom_range(3));
            r.letter = 8'($urandom_range(255));
            r.word_last = 1'($urandom_range(1));
            r.node_in = 12'($urandom_range(4095));
            r.node_in_valid = 1'($urandom_range(1));
            offer(r, 1'b0, NO_RES);
        end
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (answers_due.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic compare_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            fault_count++;
        end
    endtask

    task automatic check_result(tile_res_t got);
        tile_res_t want;
        if (answers_due.size() == 0)
        begin
            $display("%0t: result %h arrived with nothing outstanding", $time, got);
            fault_count++;
        end
        else
        begin
            want = answers_due.pop_front();
            compare_field("word_found", want.word_found, got.word_found);
            compare_field("prefix_found", want.prefix_found, got.prefix_found);
            compare_field("node_out", want.node_out, got.node_out);
            compare_field("node_out_valid", want.node_out_valid, got.node_out_valid);
            compare_field("is_terminal", want.is_terminal, got.is_terminal);
            compare_field("overflow", want.overflow, got.overflow);
        end
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (res_valid && !res_stall)
                check_result(res_data);
            if (hold_left > 0)
            begin
                res_stall <= 1'b1;
                hold_left--;
            end
            else
                res_stall <= recv_gap_pct > 0 && $urandom_range(99) < recv_gap_pct;
        end
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (res_valid && !res_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        tile_req_t r;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
        begin
            r = '{script[i].cmd, script[i].letter, script[i].last,
                  script[i].node, script[i].node_ok};
            offer(r, script[i].typed, script[i].ans);
        end
        drain();

        send_gap_pct = 21;
        recv_gap_pct = 54;
        while (request_count < 450) random_request();
        drain();

        send_gap_pct = 54;
        recv_gap_pct = 21;
        while (request_count < 900) random_request();
        drain();

        // The receiver holds off while requests keep coming, so the engine backs up.
        send_gap_pct = 0;
        recv_gap_pct = 0;
        hold_left = 400;
        while (request_count < 1500) random_request();
        drain();

        if (fault_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
